// ----- hdl/sha_pkg.sv -----
// SHA-256 engine package: round constants, initial hash values and shared types.
// No dependencies.
`default_nettype none
package sha_pkg;
    localparam int LENGTH_BITS = 64;

    typedef struct packed {
        logic       cmd_block;   // compress the 16 words carried
        logic       cmd_final;   // after this block emit the digest
        logic [511:0] words;
    } blk_cmd_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [255:0] init_hash();
        return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    endfunction
endpackage
`default_nettype wire

// ----- hdl/sha_packer.sv -----
// Front end: packs message bytes into 512-bit blocks and builds padding blocks.
// Depends on sha_pkg.
`default_nettype none
module sha_packer
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       byte_present,
    input  wire logic       is_last,
    output logic            cmd_valid,
    input  wire logic       cmd_stall,
    output blk_cmd_t        cmd
);
    logic [511:0] buf_reg, buf_next;
    logic [63:0]  cnt_reg, cnt_next;
    logic         pend_reg, pend_next;   // second padding block still owed
    logic         cv_reg, cv_next;
    blk_cmd_t     cmd_reg, cmd_next;
    logic [5:0]   pos, pos2;
    logic [511:0] wb, fin;
    logic [63:0]  cnt1, bits;

    assign cmd_valid = cv_reg;
    assign cmd       = cmd_reg;
    // hold input while a command waits or a padding block is owed
    assign in_stall  = cv_reg | pend_reg;

    always_comb
    begin
        pos  = cnt_reg[5:0];
        wb   = buf_reg;
        cnt1 = cnt_reg;
        if (byte_present)
        begin
            wb[511 - 8*pos -: 8] = data_byte;
            cnt1 = cnt_reg + 64'd1;
        end
        pos2 = cnt1[5:0];
        bits = {cnt1[60:0], 3'b000};
        if (LENGTH_BITS < 64)
            bits = bits & ((64'd1 << LENGTH_BITS) - 64'd1);
        fin = wb;
        for (int i = 0; i < 64; i++)
            if (i[5:0] > pos2)
                fin[511 - 8*i -: 8] = 8'h00;
        fin[511 - 8*pos2 -: 8] = 8'h80;
        if (pos2 < 6'd56)
            fin[63:0] = bits;

        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        cv_next   = cv_reg & cmd_stall;
        cmd_next  = cmd_reg;
        if (!cv_next && pend_reg)
        begin
            // the owed block was parked whole in buf_reg
            cv_next  = 1'b1;
            cmd_next = '{cmd_block: 1'b1, cmd_final: 1'b1, words: buf_reg};
            pend_next = 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            buf_next = wb;
            cnt_next = cnt1;
            if (is_last)
            begin
                cnt_next = 64'd0;
                cv_next  = 1'b1;
                if (byte_present && pos == 6'd63)
                begin
                    // last byte fills the block: send it, then a pad-only block
                    cmd_next  = '{cmd_block: 1'b1, cmd_final: 1'b0, words: wb};
                    pend_next = 1'b1;
                    buf_next  = {8'h80, 440'd0, bits};
                end
                else if (pos2 >= 6'd56)
                begin
                    cmd_next  = '{cmd_block: 1'b1, cmd_final: 1'b0, words: fin};
                    pend_next = 1'b1;
                    buf_next  = {448'd0, bits};
                end
                else
                    cmd_next = '{cmd_block: 1'b1, cmd_final: 1'b1, words: fin};
            end
            else if (byte_present && pos == 6'd63)
            begin
                cv_next  = 1'b1;
                cmd_next = '{cmd_block: 1'b1, cmd_final: 1'b0, words: wb};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            cv_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            cv_reg   <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        cmd_reg <= cmd_next;
    end
endmodule
`default_nettype wire

// ----- hdl/sha_core.sv -----
// Back end: 64-round compression, one round per cycle, and digest word output.
// Depends on sha_pkg.
`default_nettype none
module sha_core
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire blk_cmd_t   cmd,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [31:0]     digest_word,
    output logic [2:0]      word_index,
    output logic            last_word
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_RUN = 4'b0010, S_ADD = 4'b0100, S_EMIT = 4'b1000
    } state_t;

    state_t        st_reg, st_next;
    logic [255:0]  h_reg, h_next;
    logic [31:0]   v_reg [8];
    logic [31:0]   v_next [8];
    logic [511:0]  w_reg, w_next;
    logic [5:0]    rnd_reg, rnd_next;
    logic          fin_reg, fin_next;
    logic [2:0]    idx_reg, idx_next;
    logic [31:0]   w, x, y, t0, t1, s0, s1;

    function automatic logic [31:0] rotr(input logic [31:0] a, input int n);
        return (a >> n) | (a << (32 - n));
    endfunction

    assign cmd_stall   = (st_reg != S_IDLE);
    assign out_valid   = (st_reg == S_EMIT);
    assign digest_word = h_reg[255 - 32*idx_reg -: 32];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    always_comb
    begin
        // window: word 0 at top holds w[r]
        x  = w_reg[479:448];
        y  = w_reg[63:32];
        s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        s1 = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
        w  = w_reg[511:480];
        t0 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) | (v_reg[1] & v_reg[2]) | (v_reg[2] & v_reg[0]));
        t1 = (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + (v_reg[6] ^ (v_reg[4] & (v_reg[5] ^ v_reg[6]))) + v_reg[7]
           + round_k(rnd_reg) + w;

        st_next  = st_reg;
        h_next   = h_reg;
        v_next   = v_reg;
        w_next   = w_reg;
        rnd_next = rnd_reg;
        fin_next = fin_reg;
        idx_next = idx_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    w_next   = cmd.words;
                    fin_next = cmd.cmd_final;
                    rnd_next = 6'd0;
                    for (int k = 0; k < 8; k++)
                        v_next[k] = h_reg[255 - 32*k -: 32];
                    st_next = S_RUN;
                end
            end
            S_RUN:
            begin
                for (int k = 7; k > 0; k--)
                    v_next[k] = v_reg[k - 1];
                v_next[4] = v_reg[3] + t1;
                v_next[0] = t0 + t1;
                // advance window; new word = w[r-16]+w[r-7]+s0+s1
                w_next = {w_reg[479:0],
                          w_reg[511:480] + w_reg[223:192] + s0 + s1};
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    st_next = S_ADD;
            end
            S_ADD:
            begin
                for (int k = 0; k < 8; k++)
                    h_next[255 - 32*k -: 32] = h_reg[255 - 32*k -: 32] + v_reg[k];
                idx_next = 3'd0;
                st_next  = fin_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        h_next  = init_hash();
                        st_next = S_IDLE;
                    end
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            h_reg   <= init_hash();
            rnd_reg <= '0;
            fin_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            h_reg   <= h_next;
            rnd_reg <= rnd_next;
            fin_reg <= fin_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end
endmodule
`default_nettype wire

// ----- hdl/sha256_hash_engine.sv -----
// SHA-256 hash engine top level: byte packer front end feeding a compression core.
// Depends on sha_pkg, sha_packer, sha_core.
//
// Usage:
//   Input channel (in_valid/in_stall): one transfer per message byte
//   (byte_present=1), optionally with is_last; is_last with byte_present=0
//   ends the message without a byte (an empty message if nothing came before).
//   Output channel (out_valid/out_stall): eight transfers of digest_word,
//   word_index 0..7, last_word on the eighth.
// Throughput: bytes are taken one per cycle except at a block or message end,
//   where the packer holds its single block slot until the core takes it;
//   the core runs each 64-byte block through load, 64 rounds (one per cycle)
//   and hash update, and takes no new block until it is idle again.
// Output: with the core idle, the packer registers the last transfer as a block,
//   the core loads it, runs its rounds and adds the result into the hash, also for
//   an owed padding block; then one digest word per cycle while out_stall is low.
// Stalls: out_stall holds the current digest word; the core then refuses new
//   blocks and the packer backs up onto in_stall.
// Reset (rst_n low, asynchronous): drop any message in progress, load the
//   initial hash values and clear all handshake state.
`default_nettype none
module sha256_hash_engine
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    logic     cmd_valid;
    logic     cmd_stall;
    blk_cmd_t cmd;

    sha_packer u_packer (
        .clk, .rst_n, .in_valid, .in_stall, .data_byte, .byte_present, .is_last,
        .cmd_valid, .cmd_stall, .cmd
    );

    sha_core u_core (
        .clk, .rst_n, .cmd_valid, .cmd_stall, .cmd,
        .out_valid, .out_stall, .digest_word, .word_index, .last_word
    );
endmodule
`default_nettype wire

// ----- tb/sha256_hash_engine_tb.sv -----
// Self-checking testbench for sha256_hash_engine: byte stream in, digest words out.
// Depends on sha_pkg (LENGTH_BITS) and the engine RTL; the hash itself is computed here.
`default_nettype none
module sha256_hash_engine_tb;
    import sha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_ITEMS = 130;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_hash_engine uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .byte_present(byte_present), .is_last(is_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_item_t;

    typedef struct {
        logic [7:0] b;
        logic       present;
        logic       last;
        logic       has_known;   // digest typed in below
        logic [255:0] known;
    } stim_row_t;

    // Model state: running hash, block being packed, byte count
    logic [31:0] hv[8];
    logic [31:0] blk[16];
    logic [63:0] byte_count;

    digest_item_t expected_words[$];
    stim_row_t    stim_q[$];
    int errors = 0;
    int cycles = 0;
    int digests_seen = 0;
    int words_seen = 0;
    bit hold_receiver = 0;

    localparam logic [31:0] KTAB[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] IV[8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t0, t1;
        for (int r = 0; r < 16; r++) w[r] = blk[r];
        for (int r = 16; r < 64; r++)
        begin
            w[r] = w[r-16] + w[r-7]
                 + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3))
                 + (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10));
        end
        for (int k = 0; k < 8; k++) v[k] = hv[k];
        for (int r = 0; r < 64; r++)
        begin
            t0 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) | (v[1] & v[2]) | (v[2] & v[0]));
            t1 = (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + v[7] + KTAB[r] + w[r];
            for (int k = 7; k > 0; k--) v[k] = v[k-1];
            v[4] += t1;
            v[0] = t0 + t1;
        end
        for (int k = 0; k < 8; k++) hv[k] += v[k];
    endtask

    task automatic pack_byte(logic [5:0] pos, logic [7:0] b);
        if (pos[1:0] == 2'd0) blk[pos[5:2]] = {b, 24'h0};
        else blk[pos[5:2]] |= 32'(b) << (24 - 8 * pos[1:0]);
    endtask

    function automatic logic [255:0] hv_flat();
        return {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
    endfunction

    // Advance the model by one accepted transfer; queue the digest on a last item.
    task automatic hash_step(stim_row_t it);
        logic [5:0]  pos;
        logic [63:0] bits;
        if (it.present)
        begin
            pos = byte_count[5:0];
            pack_byte(pos, it.b);
            byte_count++;
            if (pos == 6'd63) compress();
        end
        if (it.last)
        begin
            pos = byte_count[5:0];
            pack_byte(pos, 8'h80);
            for (int k = pos[5:2] + 1; k < 16; k++) blk[k] = '0;
            if (pos >= 6'd56)
            begin
                compress();
                for (int k = 0; k < 16; k++) blk[k] = '0;
            end
            bits = byte_count << 3;
            if (LENGTH_BITS < 64) bits &= (64'd1 << LENGTH_BITS) - 64'd1;
            blk[14] = bits[63:32];
            blk[15] = bits[31:0];
            compress();
            if (it.has_known && hv_flat() != it.known)
            begin
                $error("known digest: expected %h actual model %h", it.known, hv_flat());
                errors++;
            end
            for (int k = 0; k < 8; k++)
                expected_words.push_back('{hv[k], 3'(k), k == 7});
            for (int k = 0; k < 8; k++) hv[k] = IV[k];
            byte_count = '0;
        end
    endtask

    function automatic stim_row_t mk(logic [7:0] b, logic p, logic l);
        return '{b, p, l, 1'b0, 256'h0};
    endfunction

    // Clock and cycle watchdog
    initial
    begin
        clk = 0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stall, with a forced long hold-off when asked
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_receiver) out_stall <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= hold_receiver;
            end
            else out_stall <= 1'b0;
        end
    end

    // Check each accepted digest word against the oldest expectation
    always @(posedge clk)
    begin
        digest_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected digest word %h index %0d", digest_word, word_index);
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                words_seen++;
                if (digest_word !== e.word)
                begin
                    $error("digest_word: expected %h actual %h", e.word, digest_word);
                    errors++;
                end
                if (word_index !== e.idx)
                begin
                    $error("word_index: expected %0d actual %0d", e.idx, word_index);
                    errors++;
                end
                if (last_word !== e.fin)
                begin
                    $error("last_word: expected %0d actual %0d", e.fin, last_word);
                    errors++;
                end
                if (e.fin) digests_seen++;
            end
        end
    end

    // Sender: walk the stimulus queue, one transfer per item
    task automatic send_all(bit with_gaps);
        stim_row_t it;
        int gap;
        while (stim_q.size() > 0)
        begin
            it = stim_q.pop_front();
            in_valid <= 1'b1;
            data_byte <= it.b;
            byte_present <= it.present;
            is_last <= it.last;
            do @(posedge clk); while (in_stall);
            hash_step(it);
            if (with_gaps && $urandom_range(0, 4) == 0)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
                in_valid <= 1'b0;
                data_byte <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        // drop valid and let the engine see it low before the next batch drives it
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        stim_row_t r;
        int len, kind, sent;
        in_valid = 1'b0;
        data_byte = '0;
        byte_present = 1'b0;
        is_last = 1'b0;
        rst_n = 1'b0;
        for (int k = 0; k < 8; k++) hv[k] = IV[k];
        for (int k = 0; k < 16; k++) blk[k] = '0;
        byte_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, "abc", idle item, extreme bytes, 55/56/64-byte pad cases
        r = mk(8'h00, 1'b0, 1'b1);
        r.has_known = 1'b1;
        r.known = 256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
        stim_q.push_back(r);
        stim_q.push_back(mk(8'h61, 1'b1, 1'b0));
        stim_q.push_back(mk(8'hff, 1'b0, 1'b0));          // idle item, ignored
        stim_q.push_back(mk(8'h62, 1'b1, 1'b0));
        r = mk(8'h63, 1'b1, 1'b1);
        r.has_known = 1'b1;
        r.known = 256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;
        stim_q.push_back(r);
        stim_q.push_back(mk(8'hff, 1'b1, 1'b0));
        stim_q.push_back(mk(8'h00, 1'b1, 1'b0));
        stim_q.push_back(mk(8'h00, 1'b0, 1'b1));          // end mark after bytes
        stim_q.push_back(mk(8'hff, 1'b1, 1'b1));
        send_all(1'b0);
        // 55 bytes fits one pad block; 56 forces a second block
        for (int n = 55; n <= 56; n++)
        begin
            for (int i = 0; i < n - 1; i++) stim_q.push_back(mk(8'($urandom), 1'b1, 1'b0));
            stim_q.push_back(mk(8'($urandom), 1'b1, 1'b1));
        end
        // 64 bytes: the last byte fills the block, padding goes into a block of its own
        for (int i = 0; i < 63; i++) stim_q.push_back(mk(8'($urandom), 1'b1, 1'b0));
        stim_q.push_back(mk(8'($urandom), 1'b1, 1'b1));
        send_all(1'b1);

        // Pressure: hold the receiver while several messages stream in
        hold_receiver = 1'b1;
        for (int m = 0; m < 4; m++)
            for (int i = 0; i < 3; i++) stim_q.push_back(mk(8'($urandom), 1'b1, i == 2));
        fork
            send_all(1'b0);
            begin
                repeat (400) @(posedge clk);
                hold_receiver = 1'b0;
            end
        join

        // Random messages: mostly short, a few spanning several blocks
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            len = (kind == 0) ? $urandom_range(60, 140) : $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 15) == 0) stim_q.push_back(mk(8'($urandom), 1'b0, 1'b0));
                stim_q.push_back(mk(8'($urandom), 1'b1, 1'b0));
            end
            // close with a byte or with a bare end mark
            if ($urandom_range(0, 1)) stim_q.push_back(mk(8'($urandom), 1'b1, 1'b1));
            else stim_q.push_back(mk(8'($urandom), 1'b0, 1'b1));
            sent += len + 1;
            send_all(1'b1);
        end

        while (expected_words.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d digests (%0d words) over %0d cycles", digests_seen, words_seen, cycles);
        if (errors == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/sha_pkg.sv
hdl/sha_packer.sv
hdl/sha_core.sv
hdl/sha256_hash_engine.sv
tb/sha256_hash_engine_tb.sv
